// File: hdl/qads_pkg.sv
// Package for the quote-aware delimiter scanner: widths, contexts, context update.
package qads_pkg;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int DSET_W     = 64;
    localparam int DCNT_W     = 4;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    // Parameter defaults
    localparam longint unsigned MAX_STRING_LENGTH_DEF = 64'd65536;
    localparam int              MAX_DELIMITERS_DEF    = 8;

    // Special characters
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;

    // Register select bit of paddr (registers at 0 and 8)
    localparam int REG_SEL_BIT = 3;
    localparam logic REG_DSET = 1'b0;
    localparam logic REG_DCNT = 1'b1;

    typedef enum logic [1:0] {
        CTX_NONE   = 2'd0,
        CTX_BRACE  = 2'd1,
        CTX_SQUOTE = 2'd2,
        CTX_DQUOTE = 2'd3
    } t_ctx;

    // One input word as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } t_scan_word;

    // Configuration seen by the scan core
    typedef struct packed {
        logic [DSET_W-1:0] dset;
        logic [DCNT_W-1:0] dcnt;
    } t_scan_cfg;

    // Context after seeing byte b
    function automatic t_ctx next_context(input t_ctx ctx, input logic [BYTE_W-1:0] b);
        t_ctx r;
        r = ctx;
        case (b)
            CH_LBRACE: if (ctx == CTX_NONE) r = CTX_BRACE;
            CH_RBRACE: if (ctx == CTX_BRACE) r = CTX_NONE;
            CH_SQUOTE: begin
                if (ctx == CTX_NONE) r = CTX_SQUOTE;
                else if (ctx == CTX_SQUOTE) r = CTX_NONE;
            end
            CH_DQUOTE: begin
                if (ctx == CTX_NONE) r = CTX_DQUOTE;
                else if (ctx == CTX_DQUOTE) r = CTX_NONE;
            end
            default: r = ctx;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/quote_aware_delimiter_scanner_top.sv
// Top level of the quote-aware delimiter scanner.
//
//  Channel   Dir  Handshake                       Word contents
//  s_axis    in   tvalid/tready                   tdata=data_byte, tuser=first_byte,
//                                                 tlast=last_byte
//  m_axis    out  tvalid/tready                   tdata=match_position, tuser=found
//  apb       in   psel/penable/pwrite/pready      delimiter_set @0x0, delimiter_count @0x8
//
// One word is accepted per cycle unless m_axis stalls. An accepted word is loaded
// into the input register, then the context update and delimiter compares load the
// result register from it, where the result becomes valid. Reset clears
// context, offset, answered flag and both valid bits; no clearing pass is needed. A
// stall on m_axis holds the result register, then the input register, then tready.
module quote_aware_delimiter_scanner_top
    import qads_pkg::*;
#(
    parameter longint unsigned MAX_STRING_LENGTH = MAX_STRING_LENGTH_DEF,
    parameter int              MAX_DELIMITERS    = MAX_DELIMITERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tuser,   // [0] first_byte
    input  logic                  i_s_axis_tlast,
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [POS_W-1:0]      o_m_axis_tdata,   // [15:0] match_position
    output logic                  o_m_axis_tuser,   // [0] found
    // Configuration
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    t_scan_cfg  cfg;
    logic       r_in_valid;
    t_scan_word r_in_word;
    logic       core_ready;

    qads_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // Input register: load whenever the core takes the held word or it is empty
    assign o_s_axis_tready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_word.data  <= i_s_axis_tdata;
            r_in_word.first <= i_s_axis_tuser;
            r_in_word.last  <= i_s_axis_tlast;
        end
    end

    qads_scan_core #(
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH),
        .MAX_DELIMITERS    (MAX_DELIMITERS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (r_in_valid),
        .i_word  (r_in_word),
        .o_ready (core_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_found (o_m_axis_tuser),
        .o_pos   (o_m_axis_tdata)
    );

endmodule

// File: hdl/qads_cfg_regs.sv
// APB register block: delimiter set and delimiter count.
module qads_cfg_regs
    import qads_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output t_scan_cfg             o_cfg
);

    logic [DSET_W-1:0] r_dset;
    logic [DCNT_W-1:0] r_dcnt;
    logic              wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite & o_pready;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dset <= '0;
            r_dcnt <= '0;
        end else if (wr_en) begin
            if (i_paddr[REG_SEL_BIT] == REG_DSET) begin
                r_dset <= i_pwdata[DSET_W-1:0];
            end else begin
                r_dcnt <= i_pwdata[DCNT_W-1:0];
            end
        end
    end

    // Read back
    always_comb begin
        if (i_paddr[REG_SEL_BIT] == REG_DSET) begin
            o_prdata = APB_DATA_W'(r_dset);
        end else begin
            o_prdata = APB_DATA_W'(r_dcnt);
        end
    end

    assign o_cfg.dset = r_dset;
    assign o_cfg.dcnt = r_dcnt;

endmodule

// File: hdl/qads_scan_core.sv
// Scan core: context, offset and answered state plus the result register.
module qads_scan_core
    import qads_pkg::*;
#(
    parameter longint unsigned MAX_STRING_LENGTH = MAX_STRING_LENGTH_DEF,
    parameter int              MAX_DELIMITERS    = MAX_DELIMITERS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_cfg        i_cfg,
    input  logic             i_valid,
    input  t_scan_word       i_word,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_found,
    output logic [POS_W-1:0] o_pos
);

    localparam logic [POS_W-1:0] OFFSET_CAP =
        ((MAX_STRING_LENGTH - 64'd1) > 64'd65535) ? {POS_W{1'b1}}
                                                  : POS_W'(MAX_STRING_LENGTH - 64'd1);
    localparam logic [DCNT_W-1:0] DCNT_MAX = DCNT_W'(MAX_DELIMITERS);

    t_ctx             r_ctx, n_ctx;
    logic [POS_W-1:0] r_off, n_off;
    logic             r_ans, n_ans;
    logic             r_out_valid, n_out_valid;
    logic             r_found, n_found;
    logic [POS_W-1:0] r_pos, n_pos;

    t_ctx             ctx_base;
    t_ctx             ctx_new;
    logic [POS_W-1:0] off_base;
    logic             ans_base;
    logic [DCNT_W-1:0] dcnt_eff;
    logic             is_delim;
    logic             advance;

    // Step forward when the result register is empty or being drained
    assign advance = !r_out_valid || i_ready;
    assign o_ready = advance;

    // Clamp the delimiter count
    assign dcnt_eff = (i_cfg.dcnt > DCNT_MAX) ? DCNT_MAX : i_cfg.dcnt;

    // Compare against each enabled delimiter byte in parallel
    always_comb begin
        is_delim = 1'b0;
        for (int k = 0; k < MAX_DELIMITERS; k++) begin
            if ((DCNT_W'(k) < dcnt_eff) &&
                (i_cfg.dset[k*BYTE_W +: BYTE_W] == i_word.data)) begin
                is_delim = 1'b1;
            end
        end
    end

    // A first byte restarts context, offset and answered flag
    assign ctx_base = i_word.first ? CTX_NONE : r_ctx;
    assign off_base = i_word.first ? '0 : r_off;
    assign ans_base = i_word.first ? 1'b0 : r_ans;
    assign ctx_new  = next_context(ctx_base, i_word.data);

    always_comb begin
        n_ctx       = r_ctx;
        n_off       = r_off;
        n_ans       = r_ans;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_pos       = r_pos;
        if (advance) begin
            n_out_valid = 1'b0;
            if (i_valid && !ans_base) begin
                n_ctx = ctx_new;
                n_off = (off_base < OFFSET_CAP) ? off_base + POS_W'(1) : off_base;
                n_ans = 1'b0;
                if (ctx_new == CTX_NONE && is_delim) begin
                    n_ans       = 1'b1;
                    n_out_valid = 1'b1;
                    n_found     = 1'b1;
                    n_pos       = off_base;
                end else if (i_word.last) begin
                    n_ans       = 1'b1;
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_pos       = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx       <= CTX_NONE;
            r_off       <= '0;
            r_ans       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ctx       <= n_ctx;
            r_off       <= n_off;
            r_ans       <= n_ans;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_valid = r_out_valid;
    assign o_found = r_found;
    assign o_pos   = r_pos;

endmodule

// File: verif/tb.sv
// Testbench for the quote-aware delimiter scanner: random stream traffic and a scan predictor.
`timescale 1ns / 1ps

module tb
    import qads_pkg::*;
();

    localparam int LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam longint unsigned CAP_RAW = MAX_STRING_LENGTH_DEF - 1;
    localparam logic [POS_W-1:0] POS_CAP = (CAP_RAW > 65535) ? 16'hFFFF : POS_W'(CAP_RAW);

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_match;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    t_scan_word            s_word = '0;
    logic                  m_ready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [POS_W-1:0]      o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    // Predictor copy of the registers and the scan state
    logic [DSET_W-1:0] cfg_set = '0;
    logic [DCNT_W-1:0] cfg_count = '0;
    t_ctx              scan_ctx = CTX_NONE;
    logic [POS_W-1:0]  byte_pos = '0;
    logic              answered = 1'b0;

    t_scan_word byte_queue[$];
    t_match     pending_matches[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    logic       hold_word;
    t_match     new_match;
    t_match     want;

    quote_aware_delimiter_scanner_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_word.data),
        .i_s_axis_tuser  (s_word.first),
        .i_s_axis_tlast  (s_word.last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Scan one accepted word; return 1 when it answers the current string
    function automatic bit scan_byte(input t_scan_word w, output t_match m);
        logic [POS_W-1:0] at;
        int               n;
        bit               hit;
        m = '0;
        if (w.first) begin
            scan_ctx = CTX_NONE;
            byte_pos = '0;
            answered = 1'b0;
        end
        if (answered) return 1'b0;
        at = byte_pos;
        if (byte_pos != POS_CAP) byte_pos = byte_pos + 1'b1;
        // Update the context before the delimiter test
        case (w.data)
            CH_LBRACE: if (scan_ctx == CTX_NONE) scan_ctx = CTX_BRACE;
            CH_RBRACE: if (scan_ctx == CTX_BRACE) scan_ctx = CTX_NONE;
            CH_SQUOTE: begin
                if (scan_ctx == CTX_NONE) scan_ctx = CTX_SQUOTE;
                else if (scan_ctx == CTX_SQUOTE) scan_ctx = CTX_NONE;
            end
            CH_DQUOTE: begin
                if (scan_ctx == CTX_NONE) scan_ctx = CTX_DQUOTE;
                else if (scan_ctx == CTX_DQUOTE) scan_ctx = CTX_NONE;
            end
            default: ;
        endcase
        // Counts above the table size use the whole table
        n = (cfg_count > MAX_DELIMITERS_DEF) ? MAX_DELIMITERS_DEF : int'(cfg_count);
        hit = 1'b0;
        for (int k = 0; k < n; k++)
            if (cfg_set[8*k +: 8] == w.data) hit = 1'b1;
        if (scan_ctx == CTX_NONE && hit) begin
            answered = 1'b1;
            m.found = 1'b1;
            m.pos = at;
            return 1'b1;
        end
        if (w.last) begin
            answered = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] special_char();
        case ($urandom_range(0, 3))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_SQUOTE;
            default: return CH_DQUOTE;
        endcase
    endfunction

    // Driver: predict on acceptance, then present the next word or idle
    always @(posedge i_clk) begin
        hold_word = s_valid;
        if (s_valid && o_s_axis_tready) begin
            if (scan_byte(s_word, new_match)) pending_matches.push_back(new_match);
            hold_word = 1'b0;
        end
        if (!hold_word) begin
            if (i_rst_n && byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_word <= byte_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b pos=%0d",
                             o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                want = pending_matches.pop_front();
                if (want.found !== o_m_axis_tuser || want.pos !== o_m_axis_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found=%0b pos=%0d, got found=%0b pos=%0d",
                                 want.found, want.pos, o_m_axis_tuser, o_m_axis_tdata);
                end
            end
        end
        m_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        wait (cycle_count == LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic first, input logic last);
        t_scan_word w;
        w.data = b;
        w.first = first;
        w.last = last;
        byte_queue.push_back(w);
    endtask

    // Queue a whole string with its start and end marks
    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], i == 0, i == s.len() - 1);
    endtask

    // Queue random strings: mostly well-formed, some with scrambled marks
    task automatic queue_random_text(input int words);
        int                pushed;
        int                len;
        int                k;
        bit                broken;
        logic [BYTE_W-1:0] b;
        pushed = 0;
        while (pushed < words) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: b = special_char();
                    3, 4: begin
                        k = $urandom_range(0, 7);
                        b = cfg_set[8*k +: 8];
                    end
                    default: b = BYTE_W'($urandom_range(0, 255));
                endcase
                if (broken)
                    put_byte(b, $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
                else
                    put_byte(b, i == 0, i == len - 1);
            end
            pushed += len;
        end
    endtask

    function automatic logic [DSET_W-1:0] random_delims();
        logic [DSET_W-1:0] d;
        for (int k = 0; k < 8; k++)
            d[8*k +: 8] = ($urandom_range(0, 3) == 0) ? special_char()
                                                       : BYTE_W'($urandom_range(0, 255));
        return d;
    endfunction

    // Wait until every word is sent and every result is back, then let the pipe drain
    task automatic settle();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || s_valid || pending_matches.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic sel, input logic [APB_DATA_W-1:0] value);
        logic [APB_ADDR_W-1:0] a;
        a = '0;
        a[REG_SEL_BIT] = sel;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_DSET) cfg_set = value[DSET_W-1:0];
        else cfg_count = value[DCNT_W-1:0];
    endtask

    task automatic set_delims(input logic [DSET_W-1:0] dset, input logic [DCNT_W-1:0] dcnt);
        settle();
        apb_write(REG_DSET, APB_DATA_W'(dset));
        apb_write(REG_DCNT, APB_DATA_W'(dcnt));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: sender and receiver both stall often
        send_idle_pct = 38;
        recv_idle_pct = 83;
        set_delims({8'hFF, 8'h00, CH_LBRACE, CH_DQUOTE, CH_SQUOTE, CH_RBRACE, ";", ","}, 4'd8);
        // Words with no start mark after reset
        put_byte("a", 1'b0, 1'b0);
        put_byte("b", 1'b0, 1'b0);
        put_byte(",", 1'b0, 1'b0);
        // One-byte strings, with and without a match
        queue_text("x");
        queue_text(",");
        // Closing brace and closing quotes can match
        queue_text("{,}");
        queue_text("'a{'");
        queue_text("\"x\"");
        // Stray closer outside braces
        queue_text("a}");
        // Trailing words after the answer, last mark included, are dropped
        queue_text(",bc");
        put_byte(8'h00, 1'b1, 1'b1);
        put_byte(8'hFF, 1'b1, 1'b1);
        // Empty delimiter table never matches
        set_delims({8'hFF, 8'h00, CH_LBRACE, CH_DQUOTE, CH_SQUOTE, CH_RBRACE, ";", ","}, 4'd0);
        queue_text("a,;");

        set_delims(random_delims(), 4'd8);
        queue_random_text(160);
        set_delims('0, 4'd15);
        queue_random_text(160);

        // Swap the stall rates
        send_idle_pct = 83;
        recv_idle_pct = 38;
        set_delims(random_delims(), DCNT_W'($urandom_range(1, 7)));
        queue_random_text(160);
        set_delims('1, 4'd0);
        queue_random_text(160);

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_delims(random_delims(), DCNT_W'($urandom_range(9, 15)));
        queue_random_text(160);
        set_delims(random_delims(), 4'd8);
        queue_random_text(150);

        settle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
